FILE: hdl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared definitions for the component count engine
// Default sizes, the field width, item codes and the sequencer states.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 4096;
   localparam int FIELD_W       = 11;

   // item codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLR,
      ST_E_RD,
      ST_E_GET,
      ST_E_WR,
      ST_PFX_RD,
      ST_PFX_WR,
      ST_O_RD,
      ST_O_CHK,
      ST_O_NEXT,
      ST_VCLR,
      ST_R_POP,
      ST_R_GOT,
      ST_W_CHK,
      ST_W_TGT,
      ST_W_VIS,
      ST_W_OFF1,
      ST_W_OFF2,
      ST_W_POP,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram: generic single write, single read memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/scc_count_engine.sv
// ----------------------------------------------------------------------------
// scc_count_engine: strongly connected component counter (Kosaraju)
// Edge load items: one per cycle while the sequencer is idle, no result.
// Finish item: clear counts and visited marks, count degrees, prefix sums, fill lists,
//   forward walk, clear visited marks, reverse walk; new items stall until it is done.
// The sequencer holds one memory read in flight at a time; that sets the pace of a finish.
// Synchronous reset empties the edge store and the drop flag, node count 1.
// ----------------------------------------------------------------------------
module scc_count_engine #(
   parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [scc_pkg::FIELD_W-1:0] csr_node_count,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [scc_pkg::FIELD_W-1:0] req_edge_source,
   input  logic [scc_pkg::FIELD_W-1:0] req_edge_target,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [scc_pkg::FIELD_W-1:0] rsp_component_count,
   output logic                        rsp_edges_dropped
);

   import scc_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);       // node index
   localparam int NCW = $clog2(MAX_NODES + 1);   // node count / offset address
   localparam int EA  = $clog2(MAX_EDGES);       // edge address
   localparam int EC  = $clog2(MAX_EDGES + 1);   // edge count / offset value
   localparam int SW  = NW + 2 * EC;             // walk stack entry

   // control registers
   state_type            state_ff, state_in;
   logic [FIELD_W-1:0]   csr_ff;
   logic [EC-1:0]        total_ff, total_in;
   logic                 ovf_ff, ovf_in;
   logic [NCW-1:0]       i_ff, i_in;
   logic [EC-1:0]        e_ff, e_in;
   logic                 fill_ff, fill_in;
   logic                 rev_ff, rev_in;
   logic [NW-1:0]        sd_ff, sd_in;
   logic [NCW-1:0]       fd_ff, fd_in;
   logic [NCW-1:0]       cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic [EC-1:0]        acc_f_ff, acc_f_in, acc_r_ff, acc_r_in;
   logic [NW-1:0]        src_ff, src_in, dst_ff, dst_in;
   logic [NW-1:0]        v_ff, v_in, w_ff, w_in;
   logic [EC-1:0]        k_ff, k_in, end_ff, end_in;
   logic [FIELD_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_drop_ff, rsp_drop_in;

   // memory ports
   logic                 em_we;
   logic [EA-1:0]        em_wa, em_ra;
   logic [2*NW-1:0]      em_wd, em_q;
   logic                 fo_we, ro_we;
   logic [NCW-1:0]       fo_wa, ro_wa, fo_ra, ro_ra;
   logic [EC-1:0]        fo_wd, ro_wd, fo_q, ro_q;
   logic                 ft_we, rt_we;
   logic [EA-1:0]        ft_wa, rt_wa, tg_ra;
   logic [NW-1:0]        ft_wd, rt_wd, ft_q, rt_q;
   logic                 vs_we;
   logic [NW-1:0]        vs_wa, vs_ra;
   logic                 vs_wd, vs_q;
   logic                 fs_we;
   logic [NW-1:0]        fs_wa, fs_ra, fs_wd, fs_q;
   logic                 ws_we;
   logic [NW-1:0]        ws_wa, ws_ra;
   logic [SW-1:0]        ws_wd, ws_q;

   // derived values
   logic [NCW-1:0]       n_w;
   logic                 req_acc, rsp_acc;
   logic [EC-1:0]        off_q, pfx_f, pfx_r;
   logic [NW-1:0]        tgt_q, e_src, e_dst;
   logic                 e_ok, ld_ok;
   logic [31:0]          src32, dst32;

   // effective node count: register limited to capacity
   assign n_w = (32'(csr_ff) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(csr_ff);

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign off_q = rev_ff ? ro_q : fo_q;
   assign tgt_q = rev_ff ? rt_q : ft_q;
   assign e_src = em_q[2*NW-1:NW];
   assign e_dst = em_q[NW-1:0];
   assign e_ok  = (NCW'(e_src) < n_w) && (NCW'(e_dst) < n_w);
   assign pfx_f = acc_f_ff + ((i_ff < n_w) ? fo_q : '0);
   assign pfx_r = acc_r_ff + ((i_ff < n_w) ? ro_q : '0);

   assign src32 = 32'(req_edge_source);
   assign dst32 = 32'(req_edge_target);
   assign ld_ok = (32'(total_ff) < MAX_EDGES) && (src32 >= 1) && (dst32 >= 1)
                  && (src32 <= 32'(n_w)) && (dst32 <= 32'(n_w));

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= FIELD_W'(1);
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         e_ff         <= '0;
         fill_ff      <= 1'b0;
         rev_ff       <= 1'b0;
         sd_ff        <= '0;
         fd_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_node_count;
         end
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         e_ff         <= e_in;
         fill_ff      <= fill_in;
         rev_ff       <= rev_in;
         sd_ff        <= sd_in;
         fd_ff        <= fd_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_f_ff     <= acc_f_in;
      acc_r_ff     <= acc_r_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      k_ff         <= k_in;
      end_ff       <= end_in;
      rsp_count_ff <= rsp_count_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // sequencer: next state, memory accesses
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      e_in         = e_ff;
      fill_in      = fill_ff;
      rev_in       = rev_ff;
      sd_in        = sd_ff;
      fd_in        = fd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_acc;
      acc_f_in     = acc_f_ff;
      acc_r_in     = acc_r_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      k_in         = k_ff;
      end_in       = end_ff;
      rsp_count_in = rsp_count_ff;
      rsp_drop_in  = rsp_drop_ff;

      em_we = 1'b0;
      em_wa = total_ff[EA-1:0];
      em_wd = {NW'(src32 - 32'd1), NW'(dst32 - 32'd1)};
      em_ra = e_ff[EA-1:0];
      fo_we = 1'b0;
      ro_we = 1'b0;
      fo_wa = NCW'(src_ff);
      ro_wa = NCW'(dst_ff);
      fo_wd = fo_q + EC'(1);
      ro_wd = ro_q + EC'(1);
      fo_ra = NCW'(e_src);
      ro_ra = NCW'(e_dst);
      ft_we = 1'b0;
      rt_we = 1'b0;
      ft_wa = EA'(fo_q - EC'(1));
      rt_wa = EA'(ro_q - EC'(1));
      ft_wd = dst_ff;
      rt_wd = src_ff;
      tg_ra = k_ff[EA-1:0];
      vs_we = 1'b0;
      vs_wa = w_ff;
      vs_wd = 1'b1;
      vs_ra = w_ff;
      fs_we = 1'b0;
      fs_wa = fd_ff[NW-1:0];
      fs_wd = v_ff;
      fs_ra = NW'(fd_ff - NCW'(1));
      ws_we = 1'b0;
      ws_wa = sd_ff;
      ws_wd = {v_ff, k_ff, end_ff};
      ws_ra = sd_ff - NW'(1);

      case (state_ff)
         // edge loads and finish start
         ST_IDLE: begin
            if (req_acc) begin
               if (req_action == ACT_LOAD) begin
                  if (ld_ok) begin
                     em_we    = 1'b1;
                     total_in = total_ff + EC'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  i_in   = '0;
                  cnt_in = '0;
                  fd_in  = '0;
                  sd_in  = '0;
                  state_in = (n_w == '0) ? ST_DONE : ST_CLR;
               end
            end
         end
         // clear counts and visited marks
         ST_CLR: begin
            fo_we = 1'b1;
            ro_we = 1'b1;
            fo_wa = i_ff;
            ro_wa = i_ff;
            fo_wd = '0;
            ro_wd = '0;
            vs_we = 1'b1;
            vs_wa = i_ff[NW-1:0];
            vs_wd = 1'b0;
            if (i_ff + NCW'(1) == n_w) begin
               e_in     = '0;
               fill_in  = 1'b0;
               state_in = ST_E_RD;
            end else begin
               i_in = i_ff + NCW'(1);
            end
         end
         // edge sweep: degree count or list fill
         ST_E_RD: begin
            if (e_ff == total_ff) begin
               i_in     = '0;
               acc_f_in = '0;
               acc_r_in = '0;
               rev_in   = 1'b0;
               state_in = fill_ff ? ST_O_RD : ST_PFX_RD;
            end else begin
               state_in = ST_E_GET;
            end
         end
         ST_E_GET: begin
            src_in   = e_src;
            dst_in   = e_dst;
            e_in     = e_ff + EC'(1);
            state_in = e_ok ? ST_E_WR : ST_E_RD;
         end
         ST_E_WR: begin
            fo_we = 1'b1;
            ro_we = 1'b1;
            if (fill_ff) begin
               fo_wd = fo_q - EC'(1);
               ro_wd = ro_q - EC'(1);
               ft_we = 1'b1;
               rt_we = 1'b1;
            end
            state_in = ST_E_RD;
         end
         // inclusive prefix sums, end marker at index n
         ST_PFX_RD: begin
            fo_ra    = i_ff;
            ro_ra    = i_ff;
            state_in = ST_PFX_WR;
         end
         ST_PFX_WR: begin
            fo_we    = 1'b1;
            ro_we    = 1'b1;
            fo_wa    = i_ff;
            ro_wa    = i_ff;
            fo_wd    = pfx_f;
            ro_wd    = pfx_r;
            acc_f_in = pfx_f;
            acc_r_in = pfx_r;
            if (i_ff == n_w) begin
               e_in     = '0;
               fill_in  = 1'b1;
               state_in = ST_E_RD;
            end else begin
               i_in     = i_ff + NCW'(1);
               state_in = ST_PFX_RD;
            end
         end
         // forward roots in ascending order
         ST_O_RD: begin
            w_in     = i_ff[NW-1:0];
            vs_ra    = i_ff[NW-1:0];
            state_in = ST_O_CHK;
         end
         ST_O_CHK: begin
            if (vs_q) begin
               state_in = ST_O_NEXT;
            end else begin
               vs_we = 1'b1;
               v_in  = w_ff;
               fo_ra = NCW'(w_ff);
               ro_ra = NCW'(w_ff);
               if (rev_ff) begin
                  cnt_in = cnt_ff + NCW'(1);
               end
               state_in = ST_W_OFF1;
            end
         end
         ST_O_NEXT: begin
            if (rev_ff) begin
               state_in = ST_R_POP;
            end else if (i_ff + NCW'(1) == n_w) begin
               i_in     = '0;
               state_in = ST_VCLR;
            end else begin
               i_in     = i_ff + NCW'(1);
               state_in = ST_O_RD;
            end
         end
         // visited marks cleared between passes
         ST_VCLR: begin
            vs_we = 1'b1;
            vs_wa = i_ff[NW-1:0];
            vs_wd = 1'b0;
            if (i_ff + NCW'(1) == n_w) begin
               rev_in   = 1'b1;
               state_in = ST_R_POP;
            end else begin
               i_in = i_ff + NCW'(1);
            end
         end
         // reverse roots in reverse finish order, last finished first
         ST_R_POP: begin
            if (fd_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               fd_in    = fd_ff - NCW'(1);
               state_in = ST_R_GOT;
            end
         end
         ST_R_GOT: begin
            w_in     = fs_q;
            vs_ra    = fs_q;
            state_in = ST_O_CHK;
         end
         // depth-first walk, top entry held in registers
         ST_W_CHK: begin
            if (k_ff < end_ff) begin
               state_in = ST_W_TGT;
            end else begin
               if (!rev_ff) begin
                  fs_we = 1'b1;
                  fd_in = fd_ff + NCW'(1);
               end
               if (sd_ff == '0) begin
                  state_in = ST_O_NEXT;
               end else begin
                  sd_in    = sd_ff - NW'(1);
                  state_in = ST_W_POP;
               end
            end
         end
         ST_W_TGT: begin
            w_in     = tgt_q;
            vs_ra    = tgt_q;
            k_in     = k_ff + EC'(1);
            state_in = ST_W_VIS;
         end
         ST_W_VIS: begin
            if (vs_q) begin
               state_in = ST_W_CHK;
            end else begin
               vs_we    = 1'b1;
               ws_we    = 1'b1;
               sd_in    = sd_ff + NW'(1);
               v_in     = w_ff;
               fo_ra    = NCW'(w_ff);
               ro_ra    = NCW'(w_ff);
               state_in = ST_W_OFF1;
            end
         end
         ST_W_OFF1: begin
            k_in     = off_q;
            fo_ra    = NCW'(w_ff) + NCW'(1);
            ro_ra    = NCW'(w_ff) + NCW'(1);
            state_in = ST_W_OFF2;
         end
         ST_W_OFF2: begin
            end_in   = off_q;
            state_in = ST_W_CHK;
         end
         ST_W_POP: begin
            v_in     = ws_q[SW-1:2*EC];
            k_in     = ws_q[2*EC-1:EC];
            end_in   = ws_q[EC-1:0];
            state_in = ST_W_CHK;
         end
         // result into the output register
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = FIELD_W'(cnt_ff);
               rsp_drop_in  = ovf_ff;
               total_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_component_count = rsp_count_ff;
   assign rsp_edges_dropped   = rsp_drop_ff;

   // memories
   scc_ram #(.WIDTH(2 * NW), .DEPTH(MAX_EDGES)) u_edge_mem (
      .clock(clock), .wr_en(em_we), .wr_addr(em_wa), .wr_data(em_wd),
      .rd_addr(em_ra), .rd_data(em_q)
   );
   scc_ram #(.WIDTH(EC), .DEPTH(MAX_NODES + 1)) u_fwd_off (
      .clock(clock), .wr_en(fo_we), .wr_addr(fo_wa), .wr_data(fo_wd),
      .rd_addr(fo_ra), .rd_data(fo_q)
   );
   scc_ram #(.WIDTH(EC), .DEPTH(MAX_NODES + 1)) u_rev_off (
      .clock(clock), .wr_en(ro_we), .wr_addr(ro_wa), .wr_data(ro_wd),
      .rd_addr(ro_ra), .rd_data(ro_q)
   );
   scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_fwd_tgt (
      .clock(clock), .wr_en(ft_we), .wr_addr(ft_wa), .wr_data(ft_wd),
      .rd_addr(tg_ra), .rd_data(ft_q)
   );
   scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_rev_tgt (
      .clock(clock), .wr_en(rt_we), .wr_addr(rt_wa), .wr_data(rt_wd),
      .rd_addr(tg_ra), .rd_data(rt_q)
   );
   scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
      .clock(clock), .wr_en(vs_we), .wr_addr(vs_wa), .wr_data(vs_wd),
      .rd_addr(vs_ra), .rd_data(vs_q)
   );
   scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finish_stack (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_q)
   );
   scc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_walk_stack (
      .clock(clock), .wr_en(ws_we), .wr_addr(ws_wa), .wr_data(ws_wd),
      .rd_addr(ws_ra), .rd_data(ws_q)
   );

   // checks
   a_finish_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_action == ACT_FINISH) |=> (state_ff != ST_IDLE))
      else $error("finish item did not start a run");

   a_walk_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W_CHK) |-> (NCW'(sd_ff) < n_w))
      else $error("walk stack deeper than node count");

   a_finish_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fd_ff <= n_w))
      else $error("finish stack deeper than node count");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && total_ff == '0 && !ovf_ff))
      else $error("result not posted or store not cleared");

endmodule

FILE: tb/sv/scc_count_engine_tb.sv
// ----------------------------------------------------------------------------
// scc_count_engine_tb: self-checking bench for the component count engine
// Loads directed graphs edge by edge, sends finish items and compares each
// reported component count and drop flag with a Kosaraju count worked out
// here from the accepted items. Requests idle and results stall at random.
// ----------------------------------------------------------------------------
module scc_count_engine_tb;
   import scc_pkg::*;

   localparam int NODES_CAP = MAX_NODES_DEF;
   localparam int EDGES_CAP = MAX_EDGES_DEF;

   typedef struct packed {
      logic [FIELD_W-1:0] component_count;
      logic               edges_dropped;
   } scc_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [FIELD_W-1:0] csr_node_count = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = ACT_LOAD;
   logic [FIELD_W-1:0] req_edge_source = '0;
   logic [FIELD_W-1:0] req_edge_target = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [FIELD_W-1:0] rsp_component_count;
   logic               rsp_edges_dropped;

   scc_count_engine dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_node_count      (csr_node_count),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_edge_source     (req_edge_source),
      .req_edge_target     (req_edge_target),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_component_count (rsp_component_count),
      .rsp_edges_dropped   (rsp_edges_dropped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the engine state
   logic [FIELD_W-1:0] node_count_reg = 11'd1;
   int                 edge_from [EDGES_CAP];
   int                 edge_to   [EDGES_CAP];
   int                 stored_edges = 0;
   bit                 drop_seen = 0;
   scc_result_type     expected_results [$];

   // adjacency tables for the prediction
   int fwd_off [NODES_CAP+1];
   int rev_off [NODES_CAP+1];
   int fwd_tgt [EDGES_CAP];
   int rev_tgt [EDGES_CAP];
   int fill    [NODES_CAP+1];
   bit seen    [NODES_CAP];
   int order   [NODES_CAP];
   int order_top;
   int path_node [NODES_CAP];
   int path_next [NODES_CAP];

   int  errors = 0;
   int  items_sent = 0;
   bit  no_idle = 0;
   int  hold_cycles = 0;
   int  stall_burst = 0;

   function automatic int active_nodes();
      return (node_count_reg > NODES_CAP) ? NODES_CAP : int'(node_count_reg);
   endfunction

   // depth-first walk; the forward pass records finish order
   function automatic void graph_walk(int start, bit reverse);
      int depth, v, k, w, lim;
      seen[start] = 1;
      path_node[0] = start;
      path_next[0] = reverse ? rev_off[start] : fwd_off[start];
      depth = 1;
      while (depth > 0) begin
         v = path_node[depth-1];
         k = path_next[depth-1];
         lim = reverse ? rev_off[v+1] : fwd_off[v+1];
         if (k < lim) begin
            w = reverse ? rev_tgt[k] : fwd_tgt[k];
            path_next[depth-1] = k + 1;
            if (!seen[w] && depth < NODES_CAP) begin
               seen[w] = 1;
               path_node[depth] = w;
               path_next[depth] = reverse ? rev_off[w] : fwd_off[w];
               depth++;
            end
         end else begin
            depth--;
            if (!reverse && order_top < NODES_CAP) begin
               order[order_top] = v;
               order_top++;
            end
         end
      end
   endfunction

   function automatic int count_components();
      int n, i, e, v, cnt;
      n = active_nodes();
      cnt = 0;
      for (i = 0; i <= NODES_CAP; i++) begin
         fwd_off[i] = 0;
         rev_off[i] = 0;
      end
      for (e = 0; e < stored_edges; e++)
         if (edge_from[e] < n && edge_to[e] < n) begin
            fwd_off[edge_from[e]+1]++;
            rev_off[edge_to[e]+1]++;
         end
      for (i = 0; i < n; i++) begin
         fwd_off[i+1] += fwd_off[i];
         rev_off[i+1] += rev_off[i];
      end
      for (i = 0; i <= n; i++) fill[i] = fwd_off[i];
      for (e = 0; e < stored_edges; e++)
         if (edge_from[e] < n && edge_to[e] < n) begin
            fwd_tgt[fill[edge_from[e]]] = edge_to[e];
            fill[edge_from[e]]++;
         end
      for (i = 0; i <= n; i++) fill[i] = rev_off[i];
      for (i = 0; i < n; i++)
         for (e = fwd_off[i]; e < fwd_off[i+1]; e++) begin
            rev_tgt[fill[fwd_tgt[e]]] = i;
            fill[fwd_tgt[e]]++;
         end
      for (i = 0; i < NODES_CAP; i++) seen[i] = 0;
      order_top = 0;
      for (i = 0; i < n; i++)
         if (!seen[i]) graph_walk(i, 1'b0);
      for (i = 0; i < NODES_CAP; i++) seen[i] = 0;
      while (order_top > 0) begin
         order_top--;
         v = order[order_top];
         if (!seen[v]) begin
            graph_walk(v, 1'b1);
            cnt++;
         end
      end
      return cnt;
   endfunction

   // update the shadow state for one accepted item
   task automatic track_item(logic act, logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] t);
      int n;
      scc_result_type r;
      n = active_nodes();
      if (act == ACT_LOAD) begin
         if (stored_edges >= EDGES_CAP || s < 1 || s > n || t < 1 || t > n) begin
            drop_seen = 1;
         end else begin
            edge_from[stored_edges] = int'(s) - 1;
            edge_to[stored_edges]   = int'(t) - 1;
            stored_edges++;
         end
      end else begin
         r.component_count = FIELD_W'(count_components());
         r.edges_dropped   = drop_seen;
         expected_results.insert(expected_results.size(), r);
         stored_edges = 0;
         drop_seen = 0;
      end
   endtask

   // offer one item, hold it until accepted, then maybe pause
   task automatic send_item(logic act, logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] t);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_edge_source <= s;
      req_edge_target <= t;
      do @(posedge clock); while (req_stall);
      track_item(act, s, t);
      items_sent++;
      if (!no_idle && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_edge(int s, int t);
      send_item(ACT_LOAD, FIELD_W'(s), FIELD_W'(t));
   endtask

   task automatic send_finish();
      send_item(ACT_FINISH, FIELD_W'($urandom), FIELD_W'($urandom));
   endtask

   // drop valid, drain all results and let the sequencer settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_node_count(int value);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_node_count <= FIELD_W'(value);
      do @(posedge clock); while (!csr_ready);
      node_count_reg = FIELD_W'(value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      scc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: count %0d dropped %0d",
                   rsp_component_count, rsp_edges_dropped);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_component_count !== want.component_count) begin
               $error("component_count expected %0d actual %0d",
                      want.component_count, rsp_component_count);
               errors++;
            end
            if (rsp_edges_dropped !== want.edges_dropped) begin
               $error("edges_dropped expected %0d actual %0d",
                      want.edges_dropped, rsp_edges_dropped);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern: long hold, then random bursts
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(7) == 0) begin
         stall_burst = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // reset node count of one, finish straight away
   task automatic test_reset_state();
      send_finish();
      send_edge(1, 1);
      send_edge(2, 1);
      send_finish();
   endtask

   // small graphs with cycles, self loops and out of range nodes
   task automatic test_small_graphs();
      write_node_count(6);
      send_edge(1, 2);
      send_edge(2, 3);
      send_edge(3, 1);
      send_edge(4, 4);
      send_edge(5, 4);
      send_edge(4, 6);
      send_edge(6, 5);
      send_finish();
      send_edge(0, 1);
      send_edge(1, 7);
      send_edge(2047, 2047);
      send_edge(1, 2);
      send_finish();
      send_finish();
   endtask

   // node count zero drops everything
   task automatic test_zero_nodes();
      write_node_count(0);
      send_edge(1, 1);
      send_finish();
   endtask

   // shrink the node count between loading and finish
   task automatic test_shrink_after_load();
      write_node_count(8);
      send_edge(7, 8);
      send_edge(8, 7);
      send_edge(1, 2);
      send_edge(2, 1);
      write_node_count(5);
      send_finish();
   endtask

   // largest node numbers, register above the node limit
   task automatic test_node_limit();
      write_node_count(2047);
      send_edge(1024, 1);
      send_edge(1, 1024);
      send_edge(1025, 1);
      send_finish();
      write_node_count(1024);
      send_edge(1024, 512);
      send_edge(512, 1024);
      send_finish();
   endtask

   // receiver holds off while finishes and loads keep coming
   task automatic test_backpressure();
      write_node_count(4);
      hold_cycles = 3000;
      for (int i = 0; i < 6; i++) begin
         send_edge($urandom_range(1, 4), $urandom_range(1, 4));
         send_finish();
      end
   endtask

   // random graphs, mostly well formed
   task automatic test_random_graphs(int target);
      int n, edges, pick;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 3)      n = 0;
         else if (pick < 6) n = $urandom_range(1025, 2047);
         else if (pick < 9) n = 1024;
         else               n = $urandom_range(1, 24);
         write_node_count(n);
         for (int g = 0; g < $urandom_range(1, 3); g++) begin
            edges = (n == 0 || n > 24) ? $urandom_range(0, 120) : $urandom_range(0, 3 * n);
            for (int i = 0; i < edges; i++) begin
               if ($urandom_range(19) == 0 || n == 0)
                  send_edge($urandom_range(0, 2047), $urandom_range(0, 2047));
               else if (n > 1024)
                  send_edge($urandom_range(1, 1024), $urandom_range(1, 1024));
               else
                  send_edge($urandom_range(1, n), $urandom_range(1, n));
            end
            send_finish();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_small_graphs();
      test_zero_nodes();
      test_shrink_after_load();
      test_node_limit();
      test_backpressure();
      test_random_graphs(items_sent + 1650);
      wait_idle();
      no_idle = 1;
      test_random_graphs(items_sent + 200);
      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #1000000000;
      $display("status: fail");
      $finish;
   end

endmodule
